// ===== hdl/rmsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsm_pkg
// Shared widths, constants, state codes and controller/datapath interface types
// for the running mean, deviation, minimum and maximum block.
// ----------------------------------------------------------------------------
package rmsm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int STAT_W     = SAMPLE_W + FRAC_W;
  localparam int SQ_W       = 47;
  localparam int DIV_W      = 64;
  localparam int Q_W        = 48;
  localparam int ROOT_W     = 24;
  localparam int OUT_DATA_W = COUNT_W + 2 * STAT_W + 2 * SAMPLE_W;

  // one quotient bit per step: mean numerator is sum << FRAC_W, the
  // square numerator is the sum of squares << 2*FRAC_W, both left-aligned
  localparam int MEAN_STEPS = 2 * SAMPLE_W + FRAC_W;
  localparam int SQ_STEPS   = DIV_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(SQ_STEPS);

  localparam logic [COUNT_W-1:0]         COUNT_MAX      = '1;
  localparam logic signed [SAMPLE_W-1:0] MIN_RESET_INIT = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] MAX_RESET_INIT = 16'sh8000;

  // register index, taken from the word address
  localparam logic REG_MIN_RESET = 1'b0;
  localparam logic REG_MAX_RESET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_MEAN,
    ST_SQ_LOAD,
    ST_DIV_SQ,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_load_mean;
    logic div_load_sq;
    logic div_step;
    logic root_load;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/rmsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmsm_ctrl
// Sequencer: takes one item, then steps the shared divider through the mean
// and square quotients and the root unit through the deviation.
// ----------------------------------------------------------------------------
module rmsm_ctrl import rmsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // empty statistics report zeros, skip the arithmetic
        if (status.count_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_load_mean = 1'b1;
          cnt_next          = CNT_W'(MEAN_STEPS - 1);
          state_next        = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = ST_SQ_LOAD;
        else           cnt_next   = cnt - 1'b1;
      end
      ST_SQ_LOAD: begin
        cmd.div_load_sq = 1'b1;
        cnt_next        = CNT_W'(SQ_STEPS - 1);
        state_next      = ST_DIV_SQ;
      end
      ST_DIV_SQ: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = ST_ROOT_LOAD;
        else           cnt_next   = cnt - 1'b1;
      end
      ST_ROOT_LOAD: begin
        cmd.root_load = 1'b1;
        cnt_next      = CNT_W'(ROOT_STEPS - 1);
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == '0) state_next = ST_FINISH;
        else           cnt_next   = cnt - 1'b1;
      end
      ST_FINISH: begin
        // hold until the output register can take the item
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !status.out_free) |=> state == ST_FINISH)
    else $error("result dropped while output register busy");

  a_mean_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_MEAN && cnt == '0) |=> (state == ST_SQ_LOAD && cmd.div_load_sq))
    else $error("mean division did not hand over to square division");

  a_empty_skip: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && status.count_zero) |=> state == ST_FINISH)
    else $error("empty statistics did not skip the arithmetic");

endmodule

// ===== hdl/rmsm_dp.sv =====
// ----------------------------------------------------------------------------
// rmsm_dp
// Datapath: accumulators and trackers, shared restoring divider, squaring
// multiplier, bitwise square root and the output register.
// ----------------------------------------------------------------------------
module rmsm_dp import rmsm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  output status_t                     status,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic                        clear,
  input  logic signed [SAMPLE_W-1:0]  min_reset,
  input  logic signed [SAMPLE_W-1:0]  max_reset,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [OUT_DATA_W-1:0]       out_data,
  output logic                        out_full
);

  logic signed [31:0]         sum_acc;
  logic [SQ_W-1:0]            square_acc;
  logic [COUNT_W-1:0]         count_reg;
  logic signed [SAMPLE_W-1:0] min_reg;
  logic signed [SAMPLE_W-1:0] max_reg;
  logic                       full_reg;

  logic signed [31:0] sq_prod;
  logic [31:0]        smag;

  logic [DIV_W-1:0]   num_reg;
  logic [COUNT_W-1:0] rem_reg;
  logic [COUNT_W:0]   div_trial;
  logic [COUNT_W:0]   div_diff;
  logic               div_ge;

  logic              neg_reg;
  logic [STAT_W-1:0] mq_reg;
  logic [Q_W-1:0]    msq_reg;
  logic [Q_W-1:0]    mq_sq;

  logic [Q_W-1:0]      rad_reg;
  logic [ROOT_W:0]     srem_reg;
  logic [ROOT_W-1:0]   root_reg;
  logic [ROOT_W+1:0]   root_t;
  logic [ROOT_W+1:0]   root_trial;
  logic [ROOT_W+1:0]   root_diff;
  logic                root_ge;

  logic [COUNT_W-1:0]         out_count;
  logic [STAT_W-1:0]          out_mean;
  logic [STAT_W-1:0]          out_std;
  logic signed [SAMPLE_W-1:0] out_min;
  logic signed [SAMPLE_W-1:0] out_max;

  assign sq_prod = sample * sample;
  assign smag    = sum_acc[31] ? -sum_acc : sum_acc;

  // accumulate, clear or flag saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc    <= '0;
      square_acc <= '0;
      count_reg  <= '0;
      min_reg    <= MIN_RESET_INIT;
      max_reg    <= MAX_RESET_INIT;
      full_reg   <= 1'b0;
    end else if (cmd.accept) begin
      if (clear) begin
        sum_acc    <= '0;
        square_acc <= '0;
        count_reg  <= '0;
        min_reg    <= min_reset;
        max_reg    <= max_reset;
        full_reg   <= 1'b0;
      end else if (count_reg == COUNT_MAX) begin
        full_reg <= 1'b1;
      end else begin
        sum_acc    <= sum_acc + 32'(sample);
        square_acc <= square_acc + {15'd0, sq_prod};
        count_reg  <= count_reg + 1'b1;
        if (sample > max_reg) max_reg <= sample;
        if (sample < min_reg) min_reg <= sample;
        full_reg   <= 1'b0;
      end
    end
  end

  // restoring division by the count, one quotient bit a cycle
  assign div_trial = {rem_reg, num_reg[DIV_W-1]};
  assign div_diff  = div_trial - {1'b0, count_reg};
  assign div_ge    = div_trial >= {1'b0, count_reg};
  assign mq_sq     = num_reg[STAT_W-1:0] * num_reg[STAT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load_mean) begin
      num_reg <= {smag, 32'd0};
      rem_reg <= '0;
      neg_reg <= sum_acc[31];
    end else if (cmd.div_load_sq) begin
      num_reg <= {1'b0, square_acc, 16'd0};
      rem_reg <= '0;
      // mean quotient is final here; square it for the variance term
      mq_reg  <= num_reg[STAT_W-1:0];
      msq_reg <= mq_sq;
    end else if (cmd.div_step) begin
      num_reg <= {num_reg[DIV_W-2:0], div_ge};
      rem_reg <= div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
    end
  end

  // floor square root, two radicand bits a cycle
  assign root_t     = {srem_reg[ROOT_W-1:0], rad_reg[Q_W-1 -: 2]};
  assign root_trial = {root_reg, 2'b01};
  assign root_diff  = root_t - root_trial;
  assign root_ge    = root_t >= root_trial;

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      // clamp a negative variance term to zero
      rad_reg  <= (num_reg[Q_W-1:0] > msq_reg) ? num_reg[Q_W-1:0] - msq_reg : '0;
      srem_reg <= '0;
      root_reg <= '0;
    end else if (cmd.root_step) begin
      rad_reg  <= {rad_reg[Q_W-3:0], 2'b00};
      srem_reg <= root_ge ? root_diff[ROOT_W:0] : root_t[ROOT_W:0];
      root_reg <= {root_reg[ROOT_W-2:0], root_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_full <= full_reg;
      if (count_reg == '0) begin
        out_count <= '0;
        out_mean  <= '0;
        out_std   <= '0;
        out_min   <= '0;
        out_max   <= '0;
      end else begin
        out_count <= count_reg;
        out_mean  <= neg_reg ? -mq_reg : mq_reg;
        out_std   <= root_reg;
        out_min   <= min_reg;
        out_max   <= max_reg;
      end
    end
  end

  assign out_data          = {out_max, out_min, out_std, out_mean, out_count};
  assign status.count_zero = count_reg == '0;
  assign status.out_free   = !out_valid || out_ready;

  a_full_sat: assert property (@(posedge clk) disable iff (rst)
    full_reg |-> count_reg == COUNT_MAX)
    else $error("saturation flag set below the largest count");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !clear && count_reg != COUNT_MAX)
      |=> count_reg == $past(count_reg) + 1'b1)
    else $error("count did not advance on an accumulated item");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ===== hdl/running_mean_std_min_max_core.sv =====
// ----------------------------------------------------------------------------
// running_mean_std_min_max_core
// Running count, mean, standard deviation, minimum and maximum of a stream
// of signed samples, with an APB register port for the tracker reset values.
// ----------------------------------------------------------------------------
// Each item either clears the statistics (tuser high) or adds one sample, and
// produces one result item. The block works on one item at a time and updates
// the accumulators at the accepting edge: an item that leaves a nonzero count
// reaches the output register through a load, 40 mean division steps, a load,
// 64 square division steps, a load, 24 square-root steps and the output load,
// paced by the single restoring divider and the bitwise root unit; an item
// that leaves the count at zero goes from the load state straight to the
// finish state and on into the output register. The
// next item is accepted as soon as the previous result sits in the output
// register, even if it has not been taken yet.
// Writes to min_reset and max_reset take effect at the next clear; a reset restores the initial values.
// ----------------------------------------------------------------------------
module running_mean_std_min_max_core import rmsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] sample
  input  logic                  s_axis_tuser,   // [0] clear
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] sample_count, [39:16] mean_q8,
                                                // [63:40] std_q8, [79:64] min_seen,
                                                // [95:80] max_seen
  output logic                  m_axis_tuser,   // [0] full_res
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,          // word aligned, low bits ignored
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic signed [SAMPLE_W-1:0] min_reset;
  logic signed [SAMPLE_W-1:0] max_reset;
  logic                       cfg_wr;
  cmd_t                       cmd;
  status_t                    status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_reset <= MIN_RESET_INIT;
      max_reset <= MAX_RESET_INIT;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MIN_RESET: min_reset <= pwdata[SAMPLE_W-1:0];
        REG_MAX_RESET: max_reset <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_RESET: prdata = 32'(min_reset);
      REG_MAX_RESET: prdata = 32'(max_reset);
      default:       prdata = '0;
    endcase
  end

  rmsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rmsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_axis_tdata),
    .clear     (s_axis_tuser),
    .min_reset (min_reset),
    .max_reset (max_reset),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_full  (m_axis_tuser)
  );

endmodule

// ===== dv/tb_running_mean_std_min_max_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_mean_std_min_max_core
// Stream testbench for the running count, mean, deviation, minimum and maximum
// block. A driver feeds sample and clear items from a queue, a local model of
// the accumulators works out each expected result on acceptance, and a monitor
// compares every result item field by field. Tracker reset values are written
// over APB between phases, with random stalls, a long back-pressure stretch
// and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_running_mean_std_min_max_core;
  import rmsm_pkg::*;

  typedef struct packed {
    logic                       clr;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STAT_W-1:0]   mean;
    logic [STAT_W-1:0]   dev;
    logic [SAMPLE_W-1:0] min_v;
    logic [SAMPLE_W-1:0] max_v;
    logic                full;
  } stats_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;    // [15:0] sample
  logic                  s_axis_tuser = 1'b0;  // [0] clear
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [15:0] sample_count, [39:16] mean_q8,
                                               // [63:40] std_q8, [79:64] min_seen,
                                               // [95:80] max_seen
  logic                  m_axis_tuser;         // [0] full_res
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  running_mean_std_min_max_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // register copies and accumulator state of the local model
  logic signed [SAMPLE_W-1:0] min_init_cfg = MIN_RESET_INIT;
  logic signed [SAMPLE_W-1:0] max_init_cfg = MAX_RESET_INIT;
  logic signed [31:0]         run_sum = '0;
  logic [63:0]                run_sq  = '0;
  logic [COUNT_W-1:0]         run_cnt = '0;
  logic signed [SAMPLE_W-1:0] run_min = MIN_RESET_INIT;
  logic signed [SAMPLE_W-1:0] run_max = MAX_RESET_INIT;

  sample_item_t pending_items[$];
  stats_t       expected_stats[$];
  sample_item_t cur_item;
  stats_t       want;

  int   errors = 0;
  int   n_accepted = 0;
  int   n_clears = 0;
  int   n_results = 0;
  int   n_writes = 0;
  int   src_gap = 0;
  int   sink_stall = 0;
  int   hold_left = 0;
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  logic rdy;

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v)
      note_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                              n_results, name, got, exp_v));
  endtask

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] rem, res, bitv;
    rem  = x;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // fold one item into the accumulators and return the statistics it reports
  function automatic stats_t fold_sample(input sample_item_t it);
    stats_t                     r;
    longint                     s, sl;
    logic signed [SAMPLE_W-1:0] smp;
    logic [63:0]                smag, mq, q, msq, mean_w;
    logic                       neg;
    r   = '0;
    smp = it.sample;
    s   = smp;
    if (it.clr) begin
      run_sum = '0;
      run_sq  = '0;
      run_cnt = '0;
      run_min = min_init_cfg;
      run_max = max_init_cfg;
    end else if (run_cnt == COUNT_MAX) begin
      r.full = 1'b1;
    end else begin
      run_sum = run_sum + smp;
      run_sq  = run_sq + 64'(s * s);
      run_cnt = run_cnt + 1'b1;
      if (smp > run_max) run_max = smp;
      if (smp < run_min) run_min = smp;
    end
    if (run_cnt != 0) begin
      sl     = run_sum;
      neg    = (sl < 0);
      smag   = neg ? 64'(-sl) : 64'(sl);
      mq     = (smag << FRAC_W) / run_cnt;
      q      = (run_sq << (2 * FRAC_W)) / run_cnt;
      msq    = mq * mq;
      mean_w = neg ? (64'd0 - mq) : mq;
      r.count = run_cnt;
      r.mean  = mean_w[STAT_W-1:0];
      r.dev   = STAT_W'(int_root((q > msq) ? (q - msq) : 64'd0));
      r.min_v = run_min;
      r.max_v = run_max;
    end
    return r;
  endfunction

  // source side: present queued items, hold until taken, idle in bursts
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_stats.push_back(fold_sample(cur_item));
        n_accepted++;
        if (cur_item.clr) n_clears++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          s_axis_tdata  <= cur_item.sample;
          s_axis_tuser  <= cur_item.clr;
          s_axis_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 2) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: check taken results, stall in bursts, one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_stats.size() == 0) begin
          note_mismatch("result item with no expected statistics");
        end else begin
          want = expected_stats.pop_front();
          check_field("sample_count", m_axis_tdata[15:0],  want.count);
          check_field("mean_q8",      m_axis_tdata[39:16], want.mean);
          check_field("std_q8",       m_axis_tdata[63:40], want.dev);
          check_field("min_seen",     m_axis_tdata[79:64], want.min_v);
          check_field("max_seen",     m_axis_tdata[95:80], want.max_v);
          check_field("full_res",     m_axis_tuser,        want.full);
          n_results++;
        end
      end
      if (hold_req && !hold_taken) begin
        hold_left  = 600;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        rdy = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(1, 13) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  task automatic push_item(input logic signed [15:0] v, input logic c);
    sample_item_t it;
    it.sample = v;
    it.clr    = c;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic idx, input logic signed [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MIN_RESET) min_init_cfg = val;
    else max_init_cfg = val;
    n_writes++;
  endtask

  task automatic read_check(input logic idx, input logic signed [15:0] exp_v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== exp_v)
      note_mismatch($sformatf("register %0d read 0x%0h want 0x%0h", idx,
                              prdata[15:0], exp_v));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // runs of samples with a chosen character, mostly closed by a clear
  task automatic queue_sample_runs(input int n);
    int                 added, len, style, k;
    logic signed [15:0] base, v;
    added = 0;
    while (added < n) begin
      len   = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      style = $urandom_range(0, 5);
      base  = 16'($urandom);
      for (k = 0; k < len; k++) begin
        case (style)
          0: v = 16'($urandom);
          1: v = 16'($urandom_range(0, 16)) - 16'd8;
          2: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          3: v = base;
          4: v = base + 16'($urandom_range(0, 255));
          default: v = {1'b1, 15'($urandom)};
        endcase
        push_item(v, 1'b0);
      end
      added += len;
      // leave some runs open so the next one piles on top
      if ($urandom_range(0, 7) != 0) begin
        push_item(16'($urandom), 1'b1);
        added++;
      end
      if ($urandom_range(0, 19) == 0) begin
        push_item(16'($urandom), 1'b1);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_stats.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int                 ph;
    logic signed [15:0] lo_v, hi_v;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    read_check(REG_MIN_RESET, MIN_RESET_INIT);
    read_check(REG_MAX_RESET, MAX_RESET_INIT);
    write_reg(REG_MIN_RESET, 16'sh7fff);
    write_reg(REG_MAX_RESET, 16'sh8000);

    // empty statistics, extremes, ignored sample on clear, double clear and
    // equal samples; the count stays far below saturation in this run
    push_item(16'sh7fff, 1'b1); push_item(16'sh0000, 1'b0); push_item(16'sh0000, 1'b1);
    push_item(16'sh8000, 1'b0); push_item(16'sh7fff, 1'b0); push_item(-16'sd1, 1'b0);
    push_item(16'sh0001, 1'b0); push_item(16'sh0000, 1'b0); push_item(16'sh8000, 1'b1);
    push_item(16'sh7fff, 1'b0); push_item(16'sh7fff, 1'b0); push_item(16'sh7fff, 1'b0);
    push_item(16'sh0000, 1'b1); push_item(16'shffff, 1'b1); push_item(16'sh8000, 1'b0);
    push_item(16'sh8000, 1'b0); push_item(16'sh8000, 1'b0); push_item(16'sh1234, 1'b1);
    push_item(16'sh0005, 1'b0); push_item(16'sh0005, 1'b0); push_item(16'sh0005, 1'b0);
    push_item(16'sh5555, 1'b0); push_item(16'shaaaa, 1'b0);
    wait_drained();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin lo_v = 16'sh8000; hi_v = 16'sh7fff; end
        1: begin lo_v = 16'sh0000; hi_v = 16'sh0000; end
        2: begin lo_v = 16'sh7fff; hi_v = 16'sh8000; end
        default: begin lo_v = 16'($urandom); hi_v = 16'($urandom); end
      endcase
      write_reg(REG_MIN_RESET, lo_v);
      write_reg(REG_MAX_RESET, hi_v);
      read_check(REG_MIN_RESET, lo_v);
      read_check(REG_MAX_RESET, hi_v);
      queue_sample_runs((ph == 4) ? 420 : 370);
      if (ph == 1) begin
        while (pending_items.size() > 250) @(negedge clk);
        hold_req = 1'b1;
      end
      if (ph == 4) begin
        // quiet finish: no idling on either side from here
        while (pending_items.size() > 300) @(negedge clk);
        idle_on = 1'b0;
      end
      wait_drained();
    end

    repeat (140) @(posedge clk);
    if (expected_stats.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", expected_stats.size()));
    $display("%0d items accepted (%0d clears), %0d results checked, %0d register writes",
             n_accepted, n_clears, n_results, n_writes);
    $display("covered extremes, equal samples, open and closed runs, long back-pressure");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("timeout after %0d results, %0d still expected", n_results,
             expected_stats.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
